/* rtl/core/tws_pkg.sv */
// Shared constants, codes and the configuration bundle of the timing wheel scheduler.
`default_nettype none

package tws_pkg;

    // Fixed field widths of the request, result and register map.
    localparam int REQ_W  = 2;
    localparam int KIND_W = 8;
    localparam int DLY_W  = 10;
    localparam int STAT_W = 3;
    localparam int MD_W   = 7;
    localparam int ME_W   = 6;
    localparam int LVL_W  = 6;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADV = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLR = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_CLAMP     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DROP_CON  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 3'd4;

    // Register indexes (byte address divided by four).
    localparam logic [IDX_W-1:0] REG_MAX_DELAY  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_EVENTS = 2'd1;
    localparam logic [IDX_W-1:0] REG_CON_KIND   = 2'd2;
    localparam logic [IDX_W-1:0] REG_LEVEL      = 2'd3;

    // Register reset values.
    localparam logic [MD_W-1:0]   MAX_DELAY_RST  = 7'd64;
    localparam logic [ME_W-1:0]   MAX_EVENTS_RST = 6'd32;
    localparam logic [KIND_W-1:0] CON_KIND_RST   = 8'd0;
    localparam logic [LVL_W-1:0]  LEVEL_RST      = 6'd32;

    // Effective configuration handed to the wheel controller.
    typedef struct packed {
        logic [MD_W-1:0]   md;
        logic [ME_W-1:0]   me;
        logic [KIND_W-1:0] ckind;
        logic [LVL_W-1:0]  level;
        logic              geo_clr;
    } tws_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/tws_ifs.sv */
// Request and result channel interfaces of the timing wheel scheduler.
`default_nettype none

interface tws_req_if #(
    parameter int NODE_BITS = 16
);
    import tws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [KIND_W-1:0]    event_kind;
    logic [NODE_BITS-1:0] node_a;
    logic [NODE_BITS-1:0] node_b;
    logic [DLY_W-1:0]     delay;

    modport source (
        output valid, req_type, event_kind, node_a, node_b, delay,
        input  ready
    );
    modport sink (
        input  valid, req_type, event_kind, node_a, node_b, delay,
        output ready
    );
endinterface

interface tws_rsp_if #(
    parameter int NODE_BITS = 16,
    parameter int SLOT_W    = 6,
    parameter int CNT_W     = 6,
    parameter int TOT_W     = 12
);
    import tws_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STAT_W-1:0]    status;
    logic [KIND_W-1:0]    out_kind;
    logic [NODE_BITS-1:0] out_node_a;
    logic [NODE_BITS-1:0] out_node_b;
    logic [SLOT_W-1:0]    slot_used;
    logic [CNT_W-1:0]     pending_now;
    logic [TOT_W-1:0]     pending_total;

    modport source (
        output valid, status, out_kind, out_node_a, out_node_b, slot_used,
               pending_now, pending_total,
        input  ready
    );
    modport sink (
        input  valid, status, out_kind, out_node_a, out_node_b, slot_used,
               pending_now, pending_total,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/timing_wheel_event_scheduler.sv */
// Top level of the timing wheel event scheduler with its result output stage.
`default_nettype none

// The scheduler keeps a wheel of up to SLOTS slots, each a stack of up to
// SLOT_DEPTH events, in two simple dual-port synchronous memories (slot counts
// and event store), each with one write and one read per cycle. Each request is
// one transfer on req and yields one transfer on rsp. An add of a constrained
// event also walks forward past every slot that is at the level, at most
// max_delay - 1 slots, set by one count memory read per cycle. A clear zeroes
// the count memory of all SLOTS slots, one slot per cycle. The same clearing
// pass runs after reset and from the cycle after every write to max_delay or
// max_events; req.ready stays low from that cycle until the pass ends, and
// register writes are taken throughout. A result register with a one-entry skid
// stage lets the next request be accepted while a result waits to be taken.
module timing_wheel_event_scheduler #(
    parameter int SLOTS      = 64,
    parameter int SLOT_DEPTH = 32,
    parameter int NODE_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tws_req_if.sink                    req,
    tws_rsp_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tws_pkg::ADDR_W-1:0] paddr,
    input  logic [tws_pkg::DATA_W-1:0] pwdata,
    output logic [tws_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import tws_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOT_DEPTH + 1);
    localparam int TOT_W  = $clog2(SLOTS * SLOT_DEPTH + 1);

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [KIND_W-1:0]    kind;
        logic [NODE_BITS-1:0] node_a;
        logic [NODE_BITS-1:0] node_b;
        logic [SLOT_W-1:0]    slot;
        logic [CNT_W-1:0]     pnow;
        logic [TOT_W-1:0]     ptot;
    } res_t;

    tws_cfg_t cfg;
    logic     res_valid;
    res_t     res;
    res_t     out_reg;
    res_t     skid_reg;
    logic     out_valid_reg;
    logic     skid_valid_reg;
    logic     out_free;

    tws_cfg #(
        .SLOTS      (SLOTS),
        .SLOT_DEPTH (SLOT_DEPTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tws_wheel #(
        .SLOTS      (SLOTS),
        .SLOT_DEPTH (SLOT_DEPTH),
        .NODE_BITS  (NODE_BITS)
    ) u_wheel (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .room       (!skid_valid_reg),
        .res_valid  (res_valid),
        .res_status (res.status),
        .res_kind   (res.kind),
        .res_node_a (res.node_a),
        .res_node_b (res.node_b),
        .res_slot   (res.slot),
        .res_pnow   (res.pnow),
        .res_ptot   (res.ptot)
    );

    assign out_free = !out_valid_reg || rsp.ready;

    // Output register and skid stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= skid_valid_reg && res_valid;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid stage payload.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.out_kind      = out_reg.kind;
    assign rsp.out_node_a    = out_reg.node_a;
    assign rsp.out_node_b    = out_reg.node_b;
    assign rsp.slot_used     = out_reg.slot;
    assign rsp.pending_now   = out_reg.pnow;
    assign rsp.pending_total = out_reg.ptot;

endmodule

`default_nettype wire

/* rtl/core/tws_cfg.sv */
// Configuration register file with APB-style access and effective value saturation.
`default_nettype none

module tws_cfg #(
    parameter int SLOTS      = 64,
    parameter int SLOT_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tws_pkg::ADDR_W-1:0]  paddr,
    input  logic [tws_pkg::DATA_W-1:0]  pwdata,
    output logic [tws_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output tws_pkg::tws_cfg_t           cfg
);
    import tws_pkg::*;

    localparam int SL_W = $clog2(SLOTS + 1);
    localparam int SD_W = $clog2(SLOT_DEPTH + 1);
    localparam int MW   = (SL_W > MD_W) ? SL_W : MD_W;
    localparam int EW   = (SD_W > ME_W) ? SD_W : ME_W;

    logic [MD_W-1:0]   max_delay_reg;
    logic [ME_W-1:0]   max_events_reg;
    logic [KIND_W-1:0] con_kind_reg;
    logic [LVL_W-1:0]  level_reg;
    logic              geo_reg;
    logic              geo_next;
    logic              wr;
    logic [IDX_W-1:0]  idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    // A write to either geometry register is registered into geo_reg, which starts the pass that empties the wheel.
    assign geo_next = wr && ((idx == REG_MAX_DELAY) || (idx == REG_MAX_EVENTS));

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_delay_reg  <= MAX_DELAY_RST;
            max_events_reg <= MAX_EVENTS_RST;
            con_kind_reg   <= CON_KIND_RST;
            level_reg      <= LEVEL_RST;
            geo_reg        <= 1'b0;
        end
        else
        begin
            geo_reg <= geo_next;
            if (wr)
            begin
                unique case (idx)
                    REG_MAX_DELAY:  max_delay_reg  <= pwdata[MD_W-1:0];
                    REG_MAX_EVENTS: max_events_reg <= pwdata[ME_W-1:0];
                    REG_CON_KIND:   con_kind_reg   <= pwdata[KIND_W-1:0];
                    REG_LEVEL:      level_reg      <= pwdata[LVL_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // Read data returns the raw register contents.
    always_comb
    begin
        unique case (idx)
            REG_MAX_DELAY:  prdata = DATA_W'(max_delay_reg);
            REG_MAX_EVENTS: prdata = DATA_W'(max_events_reg);
            REG_CON_KIND:   prdata = DATA_W'(con_kind_reg);
            REG_LEVEL:      prdata = DATA_W'(level_reg);
            default:        prdata = '0;
        endcase
    end

    // Saturate the geometry registers into the range the storage supports.
    always_comb
    begin
        if (max_delay_reg == '0)
            cfg.md = MD_W'(1);
        else if (MW'(max_delay_reg) > MW'(SLOTS))
            cfg.md = MD_W'(SLOTS);
        else
            cfg.md = max_delay_reg;

        if (max_events_reg == '0)
            cfg.me = ME_W'(1);
        else if (EW'(max_events_reg) > EW'(SLOT_DEPTH))
            cfg.me = ME_W'(SLOT_DEPTH);
        else
            cfg.me = max_events_reg;

        cfg.ckind   = con_kind_reg;
        cfg.level   = level_reg;
        cfg.geo_clr = geo_reg;
    end

endmodule

`default_nettype wire

/* rtl/core/tws_wheel.sv */
// Wheel controller: slot count memory, event store and the request sequencer.
`default_nettype none

module tws_wheel #(
    parameter int SLOTS      = 64,
    parameter int SLOT_DEPTH = 32,
    parameter int NODE_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tws_pkg::tws_cfg_t                     cfg,
    tws_req_if.sink                               req,
    input  logic                                  room,
    output logic                                  res_valid,
    output logic [tws_pkg::STAT_W-1:0]            res_status,
    output logic [tws_pkg::KIND_W-1:0]            res_kind,
    output logic [NODE_BITS-1:0]                  res_node_a,
    output logic [NODE_BITS-1:0]                  res_node_b,
    output logic [$clog2(SLOTS)-1:0]              res_slot,
    output logic [$clog2(SLOT_DEPTH+1)-1:0]       res_pnow,
    output logic [$clog2(SLOTS*SLOT_DEPTH+1)-1:0] res_ptot
);
    import tws_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOT_DEPTH + 1);
    localparam int TOT_W  = $clog2(SLOTS * SLOT_DEPTH + 1);
    localparam int SX_W   = ((SLOT_W > MD_W) ? SLOT_W : MD_W) + 1;
    localparam int DX_W   = (SX_W > DLY_W) ? SX_W : DLY_W;
    localparam int CMP_W  = (CNT_W > LVL_W) ? CNT_W : LVL_W;
    localparam int CM_W   = 2 * CNT_W;
    localparam int EV_N   = SLOTS * SLOT_DEPTH;
    localparam int EA_W   = $clog2(EV_N);
    localparam int EV_W   = KIND_W + 2 * NODE_BITS;

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;

    // Next slot around the wheel of cfg.md slots.
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                   input logic [MD_W-1:0]   md);
        logic [SX_W-1:0] sum;
        begin
            sum = SX_W'(s) + SX_W'(1);
            slot_inc = (sum == SX_W'(md)) ? '0 : sum[SLOT_W-1:0];
        end
    endfunction

    // Flat event store address of one stack position.
    function automatic logic [EA_W-1:0] ev_addr(input logic [SLOT_W-1:0] s,
                                                input logic [CNT_W-1:0]  i);
        begin
            ev_addr = EA_W'(s) * EA_W'(SLOT_DEPTH) + EA_W'(i);
        end
    endfunction

    // Slot count memory: {events, constrained events} per slot.
    logic [CM_W-1:0] cmem [SLOTS];
    logic [CM_W-1:0] cm_rdata_reg;
    logic            cm_we;
    logic [SLOT_W-1:0] cm_waddr;
    logic [SLOT_W-1:0] cm_raddr;
    logic [CM_W-1:0] cm_wdata;

    // Event store: {kind, node_a, node_b} per stack position.
    logic [EV_W-1:0] emem [EV_N];
    logic [EV_W-1:0] em_rdata_reg;
    logic            em_we;
    logic [EA_W-1:0] em_waddr;
    logic [EA_W-1:0] em_raddr;
    logic [EV_W-1:0] em_wdata;

    // Control state.
    logic [2:0]        state_reg,  state_next;
    logic [SLOT_W-1:0] sw_idx_reg, sw_idx_next;
    logic              sw_rsp_reg, sw_rsp_next;
    logic [SLOT_W-1:0] cur_reg,    cur_next;
    logic [CNT_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic [TOT_W-1:0]  total_reg,  total_next;

    // Request held while it is being worked on.
    logic [KIND_W-1:0]    kind_reg,   kind_next;
    logic [NODE_BITS-1:0] na_reg,     na_next;
    logic [NODE_BITS-1:0] nb_reg,     nb_next;
    logic                 is_con_reg, is_con_next;
    logic                 clamp_reg,  clamp_next;
    logic [SLOT_W-1:0]    start_reg,  start_next;
    logic [SLOT_W-1:0]    chk_reg,    chk_next;
    logic                 same_reg,   same_next;

    logic              acc;
    logic              dly_ge;
    logic [SX_W-1:0]   dly_c;
    logic [SX_W-1:0]   dsum;
    logic [SLOT_W-1:0] add_start;
    logic [SLOT_W-1:0] cur_inc;
    logic [SLOT_W-1:0] chk_inc;
    logic [CNT_W-1:0]  rd_cnt;
    logic [CNT_W-1:0]  rd_cc;
    logic              blocked;
    logic              full;

    // No request is taken in the cycle that starts a geometry clearing pass.
    assign req.ready = (state_reg == S_IDLE) && room && !cfg.geo_clr;
    assign acc       = req.valid && req.ready;

    // Target slot of an add: clamp the delay, then one wrap around the wheel.
    assign dly_ge    = DX_W'(req.delay) >= DX_W'(cfg.md);
    assign dly_c     = dly_ge ? (SX_W'(cfg.md) - SX_W'(1)) : SX_W'(req.delay);
    assign dsum      = SX_W'(cur_reg) + dly_c;
    assign add_start = (dsum >= SX_W'(cfg.md)) ? SLOT_W'(dsum - SX_W'(cfg.md))
                                               : SLOT_W'(dsum);

    assign cur_inc = slot_inc(cur_reg, cfg.md);
    assign chk_inc = slot_inc(chk_reg, cfg.md);

    assign rd_cnt  = cm_rdata_reg[CM_W-1:CNT_W];
    assign rd_cc   = cm_rdata_reg[CNT_W-1:0];
    assign blocked = is_con_reg && (CMP_W'(rd_cc) >= CMP_W'(cfg.level));
    assign full    = CMP_W'(rd_cnt) >= CMP_W'(cfg.me);

    // Memories: one write and one registered read each per cycle.
    always_ff @(posedge clk)
    begin
        if (cm_we)
            cmem[cm_waddr] <= cm_wdata;
        cm_rdata_reg <= cmem[cm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (em_we)
            emem[em_waddr] <= em_wdata;
        em_rdata_reg <= emem[em_raddr];
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        sw_idx_next  = sw_idx_reg;
        sw_rsp_next  = sw_rsp_reg;
        cur_next     = cur_reg;
        cur_cnt_next = cur_cnt_reg;
        total_next   = total_reg;
        kind_next    = kind_reg;
        na_next      = na_reg;
        nb_next      = nb_reg;
        is_con_next  = is_con_reg;
        clamp_next   = clamp_reg;
        start_next   = start_reg;
        chk_next     = chk_reg;
        same_next    = same_reg;

        cm_we    = 1'b0;
        cm_waddr = cur_reg;
        cm_wdata = '0;
        cm_raddr = cur_reg;
        em_we    = 1'b0;
        em_waddr = ev_addr(chk_reg, rd_cnt);
        em_wdata = {kind_reg, na_reg, nb_reg};
        em_raddr = ev_addr(cur_reg, cur_cnt_reg - CNT_W'(1));

        res_valid  = 1'b0;
        res_status = STAT_OK;
        res_kind   = '0;
        res_node_a = '0;
        res_node_b = '0;
        res_slot   = '0;

        unique case (state_reg)
            S_SWEEP:
            begin
                // Zero one slot entry per cycle.
                cm_we    = 1'b1;
                cm_waddr = sw_idx_reg;
                if (sw_idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                    res_valid  = sw_rsp_reg;
                end
                else
                begin
                    sw_idx_next = sw_idx_reg + SLOT_W'(1);
                end
            end

            S_IDLE:
            begin
                if (acc)
                begin
                    kind_next   = req.event_kind;
                    na_next     = req.node_a;
                    nb_next     = req.node_b;
                    is_con_next = (req.event_kind == cfg.ckind);
                    clamp_next  = dly_ge;
                    unique case (req.req_type)
                        REQ_ADD:
                        begin
                            cm_raddr   = add_start;
                            start_next = add_start;
                            chk_next   = add_start;
                            state_next = S_ADD;
                        end
                        REQ_POP:
                        begin
                            state_next = S_POP;
                        end
                        REQ_ADV:
                        begin
                            cm_raddr   = cur_inc;
                            same_next  = (cur_inc == cur_reg);
                            state_next = S_ADV;
                        end
                        REQ_CLR:
                        begin
                            sw_idx_next  = '0;
                            sw_rsp_next  = 1'b1;
                            total_next   = '0;
                            cur_cnt_next = '0;
                            state_next   = S_SWEEP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                // Counts of chk_reg arrive now; the next slot is read ahead.
                cm_raddr = chk_inc;
                if (blocked)
                begin
                    if (chk_inc == start_reg)
                    begin
                        res_valid  = 1'b1;
                        res_status = STAT_DROP_CON;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        chk_next = chk_inc;
                    end
                end
                else if (full)
                begin
                    res_valid  = 1'b1;
                    res_status = STAT_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    em_we      = 1'b1;
                    cm_we      = 1'b1;
                    cm_waddr   = chk_reg;
                    cm_wdata   = {rd_cnt + CNT_W'(1), rd_cc + CNT_W'(is_con_reg)};
                    total_next = total_reg + TOT_W'(1);
                    if (chk_reg == cur_reg)
                        cur_cnt_next = cur_cnt_reg + CNT_W'(1);
                    res_valid  = 1'b1;
                    res_status = clamp_reg ? STAT_CLAMP : STAT_OK;
                    res_slot   = chk_reg;
                    state_next = S_IDLE;
                end
            end

            S_POP:
            begin
                res_valid  = 1'b1;
                state_next = S_IDLE;
                if (cur_cnt_reg == '0)
                begin
                    res_status = STAT_POP_EMPTY;
                end
                else
                begin
                    cm_we        = 1'b1;
                    cm_waddr     = cur_reg;
                    cm_wdata     = {cur_cnt_reg - CNT_W'(1), rd_cc};
                    cur_cnt_next = cur_cnt_reg - CNT_W'(1);
                    total_next   = total_reg - TOT_W'(1);
                    {res_kind, res_node_a, res_node_b} = em_rdata_reg;
                end
            end

            S_ADV:
            begin
                // The read of the new slot was issued before the old one was cleared.
                cm_we        = 1'b1;
                cm_waddr     = cur_reg;
                cm_wdata     = '0;
                total_next   = total_reg - TOT_W'(cur_cnt_reg);
                cur_next     = cur_inc;
                cur_cnt_next = same_reg ? '0 : rd_cnt;
                res_valid    = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A geometry change empties the wheel and rewinds time.
        if (cfg.geo_clr)
        begin
            state_next   = S_SWEEP;
            sw_idx_next  = '0;
            sw_rsp_next  = 1'b0;
            cur_next     = '0;
            cur_cnt_next = '0;
            total_next   = '0;
        end
    end

    assign res_pnow = cur_cnt_next;
    assign res_ptot = total_next;

    // Control registers; a clearing pass follows reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_SWEEP;
            sw_idx_reg  <= '0;
            sw_rsp_reg  <= 1'b0;
            cur_reg     <= '0;
            cur_cnt_reg <= '0;
            total_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sw_idx_reg  <= sw_idx_next;
            sw_rsp_reg  <= sw_rsp_next;
            cur_reg     <= cur_next;
            cur_cnt_reg <= cur_cnt_next;
            total_reg   <= total_next;
        end
    end

    // Request payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        na_reg     <= na_next;
        nb_reg     <= nb_next;
        is_con_reg <= is_con_next;
        clamp_reg  <= clamp_next;
        start_reg  <= start_next;
        chk_reg    <= chk_next;
        same_reg   <= same_next;
    end

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the timing wheel event scheduler.
`timescale 1ns / 100ps

module testbench;
    import tws_pkg::*;

    localparam int NUM_SLOTS   = 64;
    localparam int NUM_DEPTH   = 32;
    localparam int NB          = 16;
    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int CHUNK       = 60;

    // One request transfer and one result transfer, at the block's widths.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [KIND_W-1:0] kind;
        logic [NB-1:0]     node_a;
        logic [NB-1:0]     node_b;
        logic [DLY_W-1:0]  delay;
    } sched_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KIND_W-1:0] kind;
        logic [NB-1:0]     node_a;
        logic [NB-1:0]     node_b;
        logic [5:0]        slot;
        logic [5:0]        now_cnt;
        logic [11:0]       total;
    } sched_res_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tws_req_if #(.NODE_BITS(NB)) req_ch ();
    tws_rsp_if #(.NODE_BITS(NB)) rsp_ch ();

    timing_wheel_event_scheduler #(
        .SLOTS(NUM_SLOTS),
        .SLOT_DEPTH(NUM_DEPTH),
        .NODE_BITS(NB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #(CLK_HALF) clk = ~clk;

    // Shadow copy of the wheel and its registers.
    logic [KIND_W-1:0] st_kind [NUM_SLOTS*NUM_DEPTH];
    logic [NB-1:0]     st_a    [NUM_SLOTS*NUM_DEPTH];
    logic [NB-1:0]     st_b    [NUM_SLOTS*NUM_DEPTH];
    int                slot_cnt [NUM_SLOTS];
    int                con_cnt  [NUM_SLOTS];
    int                cur_slot;
    int                total_cnt;
    int                cfg_md;
    int                cfg_me;
    int                cfg_ckind;
    int                cfg_level;

    // Results predicted for accepted requests, oldest first.
    sched_res_t        outcome_q [$];

    int                send_idle_pct;
    int                recv_idle_pct;
    int                error_count;
    int                result_count;
    int                settings_count;
    int                op_seen [4];
    int                status_seen [8];
    int unsigned       cycle_count = 0;

    function automatic int eff_slots();
        if (cfg_md < 1)
            return 1;
        if (cfg_md > NUM_SLOTS)
            return NUM_SLOTS;
        return cfg_md;
    endfunction

    function automatic void empty_wheel();
        foreach (slot_cnt[i])
        begin
            slot_cnt[i] = 0;
            con_cnt[i]  = 0;
        end
        total_cnt = 0;
    endfunction

    function automatic sched_req_t make_req(logic [REQ_W-1:0] op, logic [KIND_W-1:0] kind,
                                            logic [NB-1:0] a, logic [NB-1:0] b,
                                            logic [DLY_W-1:0] dly);
        sched_req_t it;
        it.req_type = op;
        it.kind     = kind;
        it.node_a   = a;
        it.node_b   = b;
        it.delay    = dly;
        return it;
    endfunction

    // Advance the shadow wheel by one request and work out its result.
    task automatic predict_outcome(input sched_req_t it, output sched_res_t res);
        int md;
        int me;
        int cur;
        int dly;
        int s;
        int start;
        int at;
        bit is_con;
        bit dropped;
        md = eff_slots();
        me = (cfg_me < 1) ? 1 : (cfg_me > NUM_DEPTH) ? NUM_DEPTH : cfg_me;
        res = '0;
        if (cur_slot >= md)
            cur_slot = 0;
        cur = cur_slot;
        case (it.req_type)
            REQ_ADD:
            begin
                dly     = int'(it.delay);
                is_con  = (int'(it.kind) == cfg_ckind);
                dropped = 1'b0;
                if (dly >= md)
                begin
                    dly        = md - 1;
                    res.status = STAT_CLAMP;
                end
                s     = (cur + dly) % md;
                start = s;
                // A constrained event walks forward to a slot below the level.
                if (is_con)
                begin
                    while (con_cnt[s] >= cfg_level && !dropped)
                    begin
                        s = (s + 1 == md) ? 0 : s + 1;
                        if (s == start)
                            dropped = 1'b1;
                    end
                end
                if (dropped)
                    res.status = STAT_DROP_CON;
                else if (slot_cnt[s] >= me)
                    res.status = STAT_FULL;
                else
                begin
                    at          = s * NUM_DEPTH + slot_cnt[s];
                    st_kind[at] = it.kind;
                    st_a[at]    = it.node_a;
                    st_b[at]    = it.node_b;
                    slot_cnt[s]++;
                    total_cnt++;
                    if (is_con)
                        con_cnt[s]++;
                    res.slot = 6'(s);
                end
            end
            REQ_POP:
            begin
                if (slot_cnt[cur] == 0)
                    res.status = STAT_POP_EMPTY;
                else
                begin
                    slot_cnt[cur]--;
                    total_cnt--;
                    at         = cur * NUM_DEPTH + slot_cnt[cur];
                    res.kind   = st_kind[at];
                    res.node_a = st_a[at];
                    res.node_b = st_b[at];
                end
            end
            REQ_ADV:
            begin
                total_cnt    -= slot_cnt[cur];
                slot_cnt[cur] = 0;
                con_cnt[cur]  = 0;
                cur++;
                if (cur >= md)
                    cur = 0;
                cur_slot = cur;
            end
            default:
            begin
                empty_wheel();
            end
        endcase
        res.now_cnt = 6'(slot_cnt[cur_slot]);
        res.total   = 12'(total_cnt);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] exp_v);
        $display("MISMATCH at result %0d: %s is %0h, expected %0h",
                 result_count, what, got_v, exp_v);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got_v,
                               input logic [31:0] exp_v);
        if (got_v !== exp_v)
            flag_mismatch(what, got_v, exp_v);
    endtask

    // Present one request, wait for its transfer and record the expected result.
    task automatic send_request(input sched_req_t it);
        sched_res_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= it.req_type;
        req_ch.event_kind <= it.kind;
        req_ch.node_a     <= it.node_a;
        req_ch.node_b     <= it.node_b;
        req_ch.delay      <= it.delay;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_outcome(it, want);
        outcome_q.push_back(want);
        op_seen[it.req_type]++;
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic quiesce();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outcome_q.size() != 0);
    endtask

    // APB write: setup cycle, access cycle, then release the bus.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAX_DELAY:
            begin
                cfg_md = value & 'h7F;
                empty_wheel();
                cur_slot = 0;
            end
            REG_MAX_EVENTS:
            begin
                cfg_me = value & 'h3F;
                empty_wheel();
                cur_slot = 0;
            end
            REG_CON_KIND:
            begin
                cfg_ckind = value & 'hFF;
            end
            default:
            begin
                cfg_level = value & 'h3F;
            end
        endcase
        settings_count++;
        @(posedge clk);
    endtask

    // Plain operations on the reset configuration, with field extremes.
    task automatic test_basic_requests();
        send_request(make_req(REQ_ADD, 8'hFF, 16'hFFFF, 16'h0000, 10'd0));
        send_request(make_req(REQ_ADD, 8'h01, 16'h0000, 16'hFFFF, 10'd1023));
        send_request(make_req(REQ_POP, 8'h00, 16'h0000, 16'h0000, 10'd0));
        send_request(make_req(REQ_POP, 8'h00, 16'h0000, 16'h0000, 10'd0));
        send_request(make_req(REQ_ADD, 8'hAA, 16'h5555, 16'hAAAA, 10'd1));
        send_request(make_req(REQ_ADV, 8'h00, 16'h0000, 16'h0000, 10'd0));
        // A clear keeps the current slot where it is.
        send_request(make_req(REQ_CLR, 8'h00, 16'h0000, 16'h0000, 10'd0));
        send_request(make_req(REQ_ADV, 8'h00, 16'h0000, 16'h0000, 10'd0));
    endtask

    // Constrained probing, drops and full slots on a tiny wheel.
    task automatic test_constraint_probe();
        quiesce();
        write_reg(REG_MAX_DELAY, 4);
        write_reg(REG_MAX_EVENTS, 2);
        write_reg(REG_CON_KIND, 'h5A);
        write_reg(REG_LEVEL, 1);
        send_request(make_req(REQ_ADD, 8'h5A, 16'h1234, 16'h4321, 10'd0));
        send_request(make_req(REQ_ADD, 8'h5A, 16'h2222, 16'h3333, 10'd0));
        // Popping a constrained event leaves the slot's constrained count alone.
        send_request(make_req(REQ_POP, 8'h00, 16'h0000, 16'h0000, 10'd0));
        send_request(make_req(REQ_ADD, 8'h5A, 16'h4444, 16'h5555, 10'd0));
        send_request(make_req(REQ_ADD, 8'h5A, 16'h6666, 16'h7777, 10'd9));
        // Every slot is at the level now, with and without a clamp.
        send_request(make_req(REQ_ADD, 8'h5A, 16'h8888, 16'h9999, 10'd0));
        send_request(make_req(REQ_ADD, 8'h5A, 16'h8888, 16'h9999, 10'd9));
        quiesce();
        write_reg(REG_LEVEL, 2);
        send_request(make_req(REQ_ADD, 8'h11, 16'hAAAA, 16'hBBBB, 10'd1));
        send_request(make_req(REQ_ADD, 8'h11, 16'hCCCC, 16'hDDDD, 10'd1));
        send_request(make_req(REQ_ADD, 8'h5A, 16'hEEEE, 16'hFFFF, 10'd1));
        send_request(make_req(REQ_ADV, 8'h00, 16'h0000, 16'h0000, 10'd0));
        send_request(make_req(REQ_CLR, 8'h00, 16'h0000, 16'h0000, 10'd0));
        quiesce();
        write_reg(REG_LEVEL, 0);
        send_request(make_req(REQ_ADD, 8'h5A, 16'h0F0F, 16'hF0F0, 10'd0));
    endtask

    // Register values outside the usable range are saturated by the block.
    task automatic test_register_extremes();
        quiesce();
        write_reg(REG_MAX_DELAY, 0);
        write_reg(REG_MAX_EVENTS, 0);
        write_reg(REG_LEVEL, 63);
        send_request(make_req(REQ_ADD, 8'h01, 16'h0101, 16'h1010, 10'd5));
        send_request(make_req(REQ_ADD, 8'h01, 16'h0202, 16'h2020, 10'd0));
        send_request(make_req(REQ_ADV, 8'h00, 16'h0000, 16'h0000, 10'd0));
        quiesce();
        write_reg(REG_MAX_DELAY, 127);
        write_reg(REG_MAX_EVENTS, 63);
        write_reg(REG_CON_KIND, 255);
        send_request(make_req(REQ_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 10'd1023));
        send_request(make_req(REQ_ADV, 8'h00, 16'h0000, 16'h0000, 10'd0));
    endtask

    // Pick a new register setting; the wheel geometry changes only now and then.
    task automatic new_setting(input bit all_regs);
        int v;
        if (all_regs || $urandom_range(1) == 0)
        begin
            case ($urandom_range(5))
                0: v = $urandom_range(4, 1);
                1: v = $urandom_range(16, 5);
                2: v = 64;
                3: v = 127;
                4: v = 0;
                default: v = $urandom_range(64, 1);
            endcase
            write_reg(REG_MAX_DELAY, v);
        end
        if (all_regs || $urandom_range(1) == 0)
        begin
            case ($urandom_range(5))
                0: v = 1;
                1: v = $urandom_range(4, 2);
                2: v = 32;
                3: v = 63;
                4: v = 0;
                default: v = $urandom_range(32, 1);
            endcase
            write_reg(REG_MAX_EVENTS, v);
        end
        case ($urandom_range(3))
            0: v = 0;
            1: v = 255;
            default: v = $urandom_range(255);
        endcase
        write_reg(REG_CON_KIND, v);
        case ($urandom_range(5))
            0: v = 0;
            1: v = 1;
            2: v = $urandom_range(8, 2);
            3: v = 32;
            4: v = 63;
            default: v = $urandom_range(32);
        endcase
        write_reg(REG_LEVEL, v);
    endtask

    function automatic sched_req_t random_request();
        sched_req_t it;
        int md;
        int pick;
        md        = eff_slots();
        it.node_a = NB'($urandom);
        it.node_b = NB'($urandom);
        it.kind   = ($urandom_range(99) < 40) ? KIND_W'(cfg_ckind) : KIND_W'($urandom);
        pick      = $urandom_range(99);
        if (pick < 55)
            it.req_type = REQ_ADD;
        else if (pick < 80)
            it.req_type = REQ_POP;
        else if (pick < 96)
            it.req_type = REQ_ADV;
        else
            it.req_type = REQ_CLR;
        // Mostly in-range delays, some anywhere, some right at the clamp point.
        case ($urandom_range(3))
            0, 1: it.delay = DLY_W'($urandom_range(md - 1));
            2: it.delay = DLY_W'($urandom_range(1023));
            default: it.delay = DLY_W'(md - 1 + $urandom_range(2));
        endcase
        return it;
    endfunction

    // Random traffic under one idling pattern, with a new setting every chunk.
    task automatic test_random_traffic(input int sidle, input int ridle, input int n);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < n; i++)
        begin
            if (i % CHUNK == 0)
            begin
                quiesce();
                new_setting(i == 0);
            end
            else if (i == CHUNK / 2)
            begin
                // Hold the sender until the wheel has answered everything.
                quiesce();
            end
            send_request(random_request());
        end
    endtask

    // Take each result transfer and compare it with the oldest prediction.
    initial
    begin : result_checker
        sched_res_t want;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (outcome_q.size() == 0)
                    flag_mismatch("result with nothing outstanding", 32'h0, 32'h0);
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", rsp_ch.status, want.status);
                    check_field("out_kind", rsp_ch.out_kind, want.kind);
                    check_field("out_node_a", rsp_ch.out_node_a, want.node_a);
                    check_field("out_node_b", rsp_ch.out_node_b, want.node_b);
                    check_field("slot_used", rsp_ch.slot_used, want.slot);
                    check_field("pending_now", rsp_ch.pending_now, want.now_cnt);
                    check_field("pending_total", rsp_ch.pending_total, want.total);
                    status_seen[want.status]++;
                end
                result_count++;
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, outcome_q.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_ADD;
        req_ch.event_kind <= '0;
        req_ch.node_a     <= '0;
        req_ch.node_b     <= '0;
        req_ch.delay      <= '0;
        error_count       = 0;
        result_count      = 0;
        settings_count    = 0;
        cfg_md            = int'(MAX_DELAY_RST);
        cfg_me            = int'(MAX_EVENTS_RST);
        cfg_ckind         = int'(CON_KIND_RST);
        cfg_level         = int'(LEVEL_RST);
        cur_slot          = 0;
        empty_wheel();
        send_idle_pct     = 16;
        recv_idle_pct     = 85;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_requests();
        test_constraint_probe();
        test_register_extremes();
        test_random_traffic(16, 85, 500);
        test_random_traffic(85, 16, 500);
        test_random_traffic(0, 0, 500);

        quiesce();
        repeat (NUM_SLOTS + 8) @(posedge clk);
        $display("Ran %0d requests (add %0d, pop %0d, advance %0d, clear %0d), %0d reg writes",
                 result_count, op_seen[REQ_ADD], op_seen[REQ_POP], op_seen[REQ_ADV],
                 op_seen[REQ_CLR], settings_count);
        $display("Outcomes: ok %0d, clamped %0d, kind dropped %0d, full %0d, empty pop %0d",
                 status_seen[STAT_OK], status_seen[STAT_CLAMP], status_seen[STAT_DROP_CON],
                 status_seen[STAT_FULL], status_seen[STAT_POP_EMPTY]);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
